### rtl/gn3d_pkg.sv
// Package for the 3D gradient noise block: word widths, default fraction
// width and the fixed 256-entry permutation table used to hash lattice corners.
// No dependencies.
package gn3d_pkg;

  localparam int COORD_W       = 24;
  localparam int NOISE_W       = 19;
  localparam int CELL_W        = 8;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [7:0] PERM [256] = '{
    8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
    8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
    8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
    8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
    8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
    8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
    8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
    8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
    8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
    8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
    8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
    8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
    8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
    8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
    8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
    8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
    8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
    8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
    8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
    8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
    8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
    8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
    8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
    8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
    8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
    8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
    8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
    8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
    8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
    8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
    8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
    8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
  };

  function automatic logic [7:0] perm_at(input logic [7:0] idx);
    return PERM[idx];
  endfunction

endpackage

### rtl/gradient_noise_3d.sv
// 3D gradient noise, eight-stage pipeline: corner hashing, quintic fade,
// corner gradients and trilinear blend. Depends on gn3d_pkg.
module gradient_noise_3d #(
  parameter int FRAC_BITS = gn3d_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [gn3d_pkg::COORD_W-1:0]        in_coord_x,
  input  logic [gn3d_pkg::COORD_W-1:0]        in_coord_y,
  input  logic [gn3d_pkg::COORD_W-1:0]        in_coord_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [gn3d_pkg::NOISE_W-1:0] out_noise_value
);
  // Usage
  // Each input word is a point (x, y, z), each coordinate unsigned with
  // FRAC_BITS fraction bits; the integer part wraps modulo 256. Each point
  // yields exactly one output word, the noise value as signed Q3.16.
  // Both channels use valid/ready; a word moves when both are high.
  // The block is an eight-stage pipeline: a point moves through the
  // stage registers in order to out_valid, and one point can be taken
  // each cycle unless all stages are full and stalled. The three chained
  // permutation look-ups, the three multiplies of the fade and the three
  // blend levels each take a stage, so the depth is set by that chain.
  // Every stage has its own valid bit and loads when it is empty or when
  // the stage after it moves, so bubbles close up. When the receiver
  // stalls, the output register holds its word and the stages behind it
  // keep filling; in_ready falls only once every stage is occupied.
  // Reset clears the valid bits only; the pipeline is empty afterwards
  // and the block takes a word in the first cycle after reset.
  // The block keeps no state between points.
  import gn3d_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int TQW = F + 5;   // fade polynomial terms
  localparam int FDW = F + 2;   // fade result, 0 to one
  localparam int DW  = F + 3;   // corner gradient values
  localparam int BW  = F + 4;   // blend values
  localparam int CW  = F + 14;  // output conversion
  localparam int NS  = 8;
  localparam int SHR = (F >= 16) ? F - 16 : 0;
  localparam int SHL = (F < 16) ? 16 - F : 0;

  localparam logic signed [TQW-1:0] FIFTEEN_ONE = TQW'(15) <<< F;
  localparam logic signed [TQW-1:0] TEN_ONE     = TQW'(10) <<< F;
  localparam logic signed [DW-1:0]  ONE_D       = DW'(1) <<< F;
  localparam logic signed [CW-1:0]  HALF_C      = CW'(1) <<< (F - 1);
  localparam logic signed [CW-1:0]  OUT_MAX     = CW'(262143);
  localparam logic signed [CW-1:0]  OUT_MIN     = -CW'(262144);

  function automatic logic signed [BW-1:0] blend(
    input logic signed [FDW-1:0] t,
    input logic signed [BW-1:0]  a,
    input logic signed [BW-1:0]  b
  );
    logic signed [BW-1:0]     d;
    logic signed [BW+FDW-1:0] p;
    d = b - a;
    p = t * d;
    return a + BW'(p >>> F);
  endfunction

  // Stage handshake
  logic [NS-1:0] v_r;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int i = 1; i < NS; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  // Stage 1: cell split, first hash level, fade terms t*t and t*(6t-15)
  logic [COORD_W-1:0] coord [3];
  logic [7:0]         cell_nxt [3];
  logic [F-1:0]       f_nxt [3];
  logic [F-1:0]       tt_nxt [3];
  logic signed [TQW-1:0] tq_nxt [3];
  logic [7:0]         ha_nxt, hb_nxt;

  logic [7:0]            s1_cell_r [3];
  logic [F-1:0]          s1_f_r [3];
  logic [F-1:0]          s1_tt_r [3];
  logic signed [TQW-1:0] s1_tq_r [3];
  logic [7:0]            s1_ha_r, s1_hb_r;

  assign coord[0] = in_coord_x;
  assign coord[1] = in_coord_y;
  assign coord[2] = in_coord_z;

  always_comb begin
    logic [COORD_W-1:0]    sh;
    logic [2*F-1:0]        sq;
    logic signed [TQW-1:0] lin;
    logic signed [2*F+5:0] pq;
    for (int i = 0; i < 3; i++) begin
      sh          = coord[i] >> F;
      cell_nxt[i] = sh[7:0];
      f_nxt[i]    = coord[i][F-1:0];
      sq          = f_nxt[i] * f_nxt[i];
      tt_nxt[i]   = sq[2*F-1:F];
      lin         = TQW'(6) * $signed({5'b0, f_nxt[i]}) - FIFTEEN_ONE;
      pq          = $signed({1'b0, f_nxt[i]}) * lin;
      tq_nxt[i]   = TQW'(pq >>> F);
    end
    ha_nxt = perm_at(cell_nxt[0]) + cell_nxt[1];
    hb_nxt = perm_at(cell_nxt[0] + 8'd1) + cell_nxt[1];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_cell_r <= cell_nxt;
      s1_f_r    <= f_nxt;
      s1_tt_r   <= tt_nxt;
      s1_tq_r   <= tq_nxt;
      s1_ha_r   <= ha_nxt;
      s1_hb_r   <= hb_nxt;
    end
  end

  // Stage 2: t^3, fade polynomial q, second hash level
  logic [F-1:0]          s2_f_r [3];
  logic [F-1:0]          s2_t3_r [3];
  logic signed [TQW-1:0] s2_q_r [3];
  logic [7:0]            s2_hc_r [4];   // aa, ba, ab, bb
  logic [F-1:0]          t3_nxt [3];
  logic [7:0]            hc_nxt [4];

  always_comb begin
    logic [2*F-1:0] pc;
    for (int i = 0; i < 3; i++) begin
      pc        = s1_tt_r[i] * s1_f_r[i];
      t3_nxt[i] = pc[2*F-1:F];
    end
    hc_nxt[0] = perm_at(s1_ha_r) + s1_cell_r[2];
    hc_nxt[1] = perm_at(s1_hb_r) + s1_cell_r[2];
    hc_nxt[2] = perm_at(s1_ha_r + 8'd1) + s1_cell_r[2];
    hc_nxt[3] = perm_at(s1_hb_r + 8'd1) + s1_cell_r[2];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_f_r  <= s1_f_r;
      s2_t3_r <= t3_nxt;
      for (int i = 0; i < 3; i++) s2_q_r[i] <= s1_tq_r[i] + TEN_ONE;
      s2_hc_r <= hc_nxt;
    end
  end

  // Stage 3: fade = t^3 * q, corner gradient selectors
  logic [F-1:0]          s3_f_r [3];
  logic signed [FDW-1:0] s3_u_r [3];
  logic [2:0]            s3_g_r [8];
  logic signed [FDW-1:0] u_nxt [3];
  logic [2:0]            g_nxt [8];

  always_comb begin
    logic signed [2*F+5:0] pf;
    logic [7:0]            pv;
    for (int i = 0; i < 3; i++) begin
      pf       = $signed({1'b0, s2_t3_r[i]}) * s2_q_r[i];
      u_nxt[i] = FDW'(pf >>> F);
    end
    for (int k = 0; k < 4; k++) begin
      pv           = perm_at(s2_hc_r[k]);
      g_nxt[k]     = pv[2:0];
      pv           = perm_at(s2_hc_r[k] + 8'd1);
      g_nxt[k + 4] = pv[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_f_r <= s2_f_r;
      s3_u_r <= u_nxt;
      s3_g_r <= g_nxt;
    end
  end

  // Stage 4: corner values as sign-flipped sums of the offsets.
  // Corner k uses the far x offset when bit 0 of k is set, far y with
  // bit 1 and far z with bit 2.
  logic signed [FDW-1:0] s4_u_r [3];
  logic signed [DW-1:0]  s4_d_r [8];
  logic signed [DW-1:0]  d_nxt [8];

  always_comb begin
    logic signed [DW-1:0] near_o [3];
    logic signed [DW-1:0] far_o [3];
    logic signed [DW-1:0] o [3];
    for (int i = 0; i < 3; i++) begin
      near_o[i] = $signed(DW'(s3_f_r[i]));
      far_o[i]  = near_o[i] - ONE_D;
    end
    for (int k = 0; k < 8; k++) begin
      for (int i = 0; i < 3; i++) begin
        o[i] = k[i] ? far_o[i] : near_o[i];
        if (s3_g_r[k][i]) o[i] = -o[i];
      end
      d_nxt[k] = o[0] + o[1] + o[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_u_r <= s3_u_r;
      s4_d_r <= d_nxt;
    end
  end

  // Stage 5: blend along x
  logic signed [FDW-1:0] s5_v_r, s5_w_r;
  logic signed [BW-1:0]  s5_l_r [4];

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_v_r <= s4_u_r[1];
      s5_w_r <= s4_u_r[2];
      for (int k = 0; k < 4; k++) begin
        s5_l_r[k] <= blend(s4_u_r[0], BW'(s4_d_r[2*k]), BW'(s4_d_r[2*k+1]));
      end
    end
  end

  // Stage 6: blend along y
  logic signed [FDW-1:0] s6_w_r;
  logic signed [BW-1:0]  s6_m_r [2];

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s6_w_r    <= s5_w_r;
      s6_m_r[0] <= blend(s5_v_r, s5_l_r[0], s5_l_r[1]);
      s6_m_r[1] <= blend(s5_v_r, s5_l_r[2], s5_l_r[3]);
    end
  end

  // Stage 7: blend along z
  logic signed [BW-1:0] s7_r_r;

  always_ff @(posedge clk) begin
    if (en[6]) s7_r_r <= blend(s6_w_r, s6_m_r[0], s6_m_r[1]);
  end

  // Stage 8: halve, offset by one half, convert to Q3.16 and saturate
  logic signed [NOISE_W-1:0] out_nxt;
  logic signed [NOISE_W-1:0] s8_out_r;

  always_comb begin
    logic signed [CW-1:0] val;
    val = CW'(s7_r_r >>> 1) + HALF_C;
    val = (val >>> SHR) <<< SHL;
    if (val > OUT_MAX)      out_nxt = NOISE_W'(OUT_MAX);
    else if (val < OUT_MIN) out_nxt = NOISE_W'(OUT_MIN);
    else                    out_nxt = NOISE_W'(val);
  end

  always_ff @(posedge clk) begin
    if (en[7]) s8_out_r <= out_nxt;
  end

  assign out_noise_value = s8_out_r;

`ifndef NO_ASSERTIONS
  a_ready_when_tail_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[NS-1] |-> in_ready)
    else $error("input refused while the output stage is empty");

  a_word_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !(out_valid && out_ready))
      |=> $countones(v_r) == $past($countones(v_r)) + 1)
    else $error("accepted word not held in the pipeline");

  a_word_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    (!(in_valid && in_ready) && out_valid && out_ready)
      |=> $countones(v_r) + 1 == $past($countones(v_r)))
    else $error("delivered word not removed from the pipeline");

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (&v_r && !out_ready) |-> !in_ready)
    else $error("input taken while the pipeline is full and stalled");
`endif

endmodule

### dv/gradient_noise_3d_checker.sv
// Checker for the 3D gradient noise block: predicts each noise word from the
// accepted coordinates and compares it with the result channel.
// Depends on gn3d_pkg.
module gradient_noise_3d_checker #(
  parameter int FRAC_BITS = gn3d_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [gn3d_pkg::COORD_W-1:0]        in_coord_x,
  input  logic [gn3d_pkg::COORD_W-1:0]        in_coord_y,
  input  logic [gn3d_pkg::COORD_W-1:0]        in_coord_z,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [gn3d_pkg::NOISE_W-1:0] out_noise_value,
  output int                                  fail_count,
  output int                                  pending
);
  import gn3d_pkg::*;

  localparam longint ONE = longint'(1) << FRAC_BITS;

  logic signed [NOISE_W-1:0] noise_q[$];

  function automatic longint fmul(longint a, longint b);
    return (a * b) >>> FRAC_BITS;
  endfunction

  function automatic longint fade5(longint t);
    longint q;
    q = fmul(t, 6 * t - 15 * ONE) + 10 * ONE;
    return fmul(fmul(fmul(t, t), t), q);
  endfunction

  function automatic longint lerp(longint t, longint a, longint b);
    return a + fmul(t, b - a);
  endfunction

  function automatic longint grad(int unsigned h, longint dx, longint dy, longint dz);
    return ((h & 1) ? -dx : dx) + ((h & 2) ? -dy : dy) + ((h & 4) ? -dz : dz);
  endfunction

  function automatic int unsigned hsh(int unsigned idx);
    return 32'(PERM[idx[7:0]]);
  endfunction

  function automatic logic signed [NOISE_W-1:0] noise_of(logic [COORD_W-1:0] px,
      logic [COORD_W-1:0] py, logic [COORD_W-1:0] pz);
    int unsigned cx, cy, cz, ha, haa, hab, hb, hba, hbb;
    longint fx, fy, fz, gx, gy, gz, u, v, w, lo, hi, r, val;
    cx = 32'((longint'(px) >> FRAC_BITS) & 255);
    cy = 32'((longint'(py) >> FRAC_BITS) & 255);
    cz = 32'((longint'(pz) >> FRAC_BITS) & 255);
    fx = longint'(px) & (ONE - 1);
    fy = longint'(py) & (ONE - 1);
    fz = longint'(pz) & (ONE - 1);
    gx = fx - ONE; gy = fy - ONE; gz = fz - ONE;
    u = fade5(fx); v = fade5(fy); w = fade5(fz);
    ha = hsh(cx) + cy;
    haa = hsh(ha) + cz;
    hab = hsh(ha + 1) + cz;
    hb = hsh(cx + 1) + cy;
    hba = hsh(hb) + cz;
    hbb = hsh(hb + 1) + cz;
    lo = lerp(v, lerp(u, grad(hsh(haa), fx, fy, fz), grad(hsh(hba), gx, fy, fz)),
                 lerp(u, grad(hsh(hab), fx, gy, fz), grad(hsh(hbb), gx, gy, fz)));
    hi = lerp(v, lerp(u, grad(hsh(haa + 1), fx, fy, gz), grad(hsh(hba + 1), gx, fy, gz)),
                 lerp(u, grad(hsh(hab + 1), fx, gy, gz), grad(hsh(hbb + 1), gx, gy, gz)));
    r = lerp(w, lo, hi);
    val = (r >>> 1) + (ONE >>> 1);
    if (FRAC_BITS >= 16) val = val >>> (FRAC_BITS - 16);
    else val = val <<< (16 - FRAC_BITS);
    if (val < -262144) val = -262144;
    if (val > 262143) val = 262143;
    return val[NOISE_W-1:0];
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch: %s", what);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) noise_q.push_back(noise_of(in_coord_x, in_coord_y, in_coord_z));
      if (out_valid && out_ready) begin
        if (noise_q.size() == 0) begin
          report_mismatch($sformatf("unexpected noise word %0d", out_noise_value));
        end else begin
          if (out_noise_value !== noise_q[0])
            report_mismatch($sformatf("noise_value got %0d want %0d",
                                      out_noise_value, noise_q[0]));
          void'(noise_q.pop_front());
        end
      end
      pending <= noise_q.size();
    end
  end
endmodule

### dv/gradient_noise_3d_test.sv
// Top of the gradient noise testbench: clock, reset, stimulus and verdict.
// Depends on gn3d_pkg, gradient_noise_3d and gradient_noise_3d_checker.
module gradient_noise_3d_test;
  import gn3d_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [COORD_W-1:0] in_coord_x = '0, in_coord_y = '0, in_coord_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [NOISE_W-1:0] out_noise_value;
  int fail_count, pending;
  // When set, the receiver never idles; when hold is set, it refuses all words.
  bit calm = 1'b0;
  bit hold = 1'b0;

  gradient_noise_3d u_dut (.*);
  gradient_noise_3d_checker u_chk (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The receiver idles at random, except during the calm stretch and while held.
  always @(posedge clk) begin
    out_ready <= !hold && (calm || $urandom_range(99) >= 18);
  end

  // Offers one word and keeps it steady until the block takes it. Idle cycles
  // come before the word so that valid never drops once raised; the caller
  // lowers valid once it has no further word to offer.
  task automatic send_word(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                           logic [COORD_W-1:0] z);
    while (!calm && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_coord_x <= x;
    in_coord_y <= y;
    in_coord_z <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Coordinates just inside a cell border half the time, else full-range words.
  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(3))
      0: return 24'($urandom_range(0, 'hFFFFFF));
      1: return {8'($urandom_range(0, 255)), 16'(16'hFFFF - $urandom_range(0, 3))};
      2: return {8'($urandom_range(0, 255)), 16'(($urandom_range(0, 3)))};
      default: return 24'($urandom);
    endcase
  endfunction

  initial begin
    logic [COORD_W-1:0] edges [6];
    edges = '{24'h000000, 24'hFFFFFF, 24'h00FFFF, 24'hFF0000, 24'h008000, 24'h7F8001};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: extreme coordinates and the wrap of the cell index.
    foreach (edges[i]) send_word(edges[i], edges[(i + 1) % 6], edges[(i + 3) % 6]);
    send_word(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_word(24'hAAAAAA, 24'h555555, 24'hAAAAAA);
    send_word(24'h555555, 24'hAAAAAA, 24'h555555);
    // Receiver held off for a long stretch while words keep coming.
    hold = 1'b1;
    fork
      begin
        repeat (200) @(posedge clk);
        hold = 1'b0;
      end
      begin
        repeat (40) send_word(rand_coord(), rand_coord(), rand_coord());
        in_valid <= 1'b0;
      end
    join
    // Sender pauses until every expected word has come back.
    while (pending != 0) @(posedge clk);
    for (int n = 0; n < 1000; n++) begin
      calm = (n >= 400 && n < 550);
      send_word(rand_coord(), rand_coord(), rand_coord());
    end
    in_valid <= 1'b0;
    calm = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #200000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

### sim.f
rtl/gn3d_pkg.sv
rtl/gradient_noise_3d.sv
dv/gradient_noise_3d_checker.sv
dv/gradient_noise_3d_test.sv
